[hw/rtl/ostc_pkg.sv]
// Package for the two-channel system timer: register indexes, command codes,
// widths and the prescale divider helper.
// No dependencies; every other file of the timer imports this package.
package ostc_pkg;

   localparam int COMPARE_WIDTH = 32;
   localparam int DATA_W        = 32;
   localparam int FREE_W        = 64;
   localparam int DIV_W         = 6;

   typedef logic [1:0]               command_type;
   typedef logic [3:0]               index_type;
   typedef logic [DATA_W-1:0]        data_type;
   typedef logic [COMPARE_WIDTH-1:0] compare_type;
   typedef logic [FREE_W-1:0]        free_type;
   typedef logic [DIV_W-1:0]         divider_type;

   localparam command_type CMD_TICK  = 2'd0;
   localparam command_type CMD_READ  = 2'd1;
   localparam command_type CMD_WRITE = 2'd2;

   localparam index_type REG_PRESCALE = 4'd0;
   localparam index_type REG_CLEAR    = 4'd2;
   localparam index_type REG_FLAG     = 4'd3;
   localparam index_type REG_MASK     = 4'd4;
   localparam index_type REG_CMPVAL   = 4'd5;
   localparam index_type REG_COUNT    = 4'd6;
   localparam index_type REG_FREE_LO  = 4'd8;
   localparam index_type REG_FREE_HI  = 4'd9;
   localparam index_type REG_EN_SET   = 4'd13;
   localparam index_type REG_EN_CLR   = 4'd14;

   // Last divider count of a period: code c divides the tick rate by 4^c.
   function automatic divider_type div_limit(input logic [1:0] code);
      divider_type lim;
      unique case (code)
         2'd0: lim = 6'd0;
         2'd1: lim = 6'd3;
         2'd2: lim = 6'd15;
         default: lim = 6'd63;
      endcase
      return lim;
   endfunction

endpackage

[hw/rtl/ostc_if.sv]
// Channel interfaces of the system timer: the request channel and the
// response channel, each with valid/ready and its payload. Uses ostc_pkg.
interface ostc_req_if import ostc_pkg::*; ();
   logic        valid;
   logic        ready;
   command_type command;
   index_type   word_index;
   data_type    write_data;

   modport source (output valid, command, word_index, write_data, input ready);
   modport sink   (input valid, command, word_index, write_data, output ready);
endinterface

interface ostc_rsp_if import ostc_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type read_data;
   logic     irq;

   modport source (output valid, read_data, irq, input ready);
   modport sink   (input valid, read_data, irq, output ready);
endinterface

[hw/rtl/os_timer_compare_and_free_counter.sv]
// Two-channel system timer: prescaled compare timer plus free-running 64-bit
// counter, with a two-entry response buffer. Uses ostc_pkg and ostc_if.sv.
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    command, word_index, write_data
//   rsp_chan  out        valid/ready    read_data, irq
//
// The timer state updates at the accepting edge and the response is registered
// at that same edge.
// The response buffer holds two entries, so a request is still taken while one
// response waits; req ready drops only when both entries are full.
// Synchronous reset clears all timer state (mask set) and empties the buffer.
module os_timer_compare_and_free_counter
   import ostc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ostc_req_if.sink     req_chan,
   ostc_rsp_if.source   rsp_chan
);

   typedef struct packed {
      data_type read_data;
      logic     irq;
   } rsp_payload_type;

   logic [3:0]  prescale_ff, prescale_in;
   logic [1:0]  enable_ff, enable_in;
   divider_type div_one_ff, div_one_in;
   divider_type div_two_ff, div_two_in;
   compare_type count_ff, count_in;
   compare_type cmpval_ff, cmpval_in;
   logic        flag_ff, flag_in;
   logic        mask_ff, mask_in;
   free_type    free_ff, free_in;
   data_type    latch_ff, latch_in;

   rsp_payload_type out_ff, skid_ff, result;
   logic            out_valid_ff, skid_valid_ff;
   logic            push, pop;
   compare_type     count_next;

   assign req_chan.ready = !skid_valid_ff;
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = out_valid_ff && rsp_chan.ready;
   assign count_next     = count_ff + 1'b1;

   always_comb begin
      prescale_in = prescale_ff;
      enable_in   = enable_ff;
      div_one_in  = div_one_ff;
      div_two_in  = div_two_ff;
      count_in    = count_ff;
      cmpval_in   = cmpval_ff;
      flag_in     = flag_ff;
      mask_in     = mask_ff;
      free_in     = free_ff;
      latch_in    = latch_ff;
      result.read_data = '0;

      unique case (req_chan.command)
         CMD_TICK: begin
            if (enable_ff[0]) begin
               if (div_one_ff >= div_limit(prescale_ff[1:0])) begin
                  div_one_in = '0;
                  if (count_next == cmpval_ff) begin
                     flag_in  = 1'b1;
                     count_in = '0;
                  end else begin
                     count_in = count_next;
                  end
               end else begin
                  div_one_in = div_one_ff + 1'b1;
               end
            end
            if (enable_ff[1]) begin
               if (div_two_ff >= div_limit(prescale_ff[3:2])) begin
                  div_two_in = '0;
                  free_in    = free_ff + 1'b1;
               end else begin
                  div_two_in = div_two_ff + 1'b1;
               end
            end
         end
         CMD_READ: begin
            unique case (req_chan.word_index)
               REG_PRESCALE: result.read_data = DATA_W'(prescale_ff);
               REG_FLAG:     result.read_data = DATA_W'(flag_ff);
               REG_MASK:     result.read_data = DATA_W'(mask_ff);
               REG_CMPVAL:   result.read_data = DATA_W'(cmpval_ff);
               REG_COUNT:    result.read_data = DATA_W'(count_ff);
               REG_FREE_LO: begin
                  // Reading the low word snapshots the high word.
                  latch_in         = free_ff[FREE_W-1:DATA_W];
                  result.read_data = free_ff[DATA_W-1:0];
               end
               REG_FREE_HI:  result.read_data = latch_ff;
               default:      result.read_data = '0;
            endcase
         end
         CMD_WRITE: begin
            unique case (req_chan.word_index)
               REG_PRESCALE: prescale_in = req_chan.write_data[3:0];
               REG_CLEAR: begin
                  if (req_chan.write_data[0]) begin
                     count_in   = '0;
                     div_one_in = '0;
                  end
                  if (req_chan.write_data[1]) begin
                     free_in    = '0;
                     div_two_in = '0;
                  end
               end
               REG_FLAG:   if (!req_chan.write_data[0]) flag_in = 1'b0;
               REG_MASK:   mask_in   = req_chan.write_data[0];
               REG_CMPVAL: cmpval_in = req_chan.write_data[COMPARE_WIDTH-1:0];
               REG_COUNT:  count_in  = req_chan.write_data[COMPARE_WIDTH-1:0];
               REG_EN_SET: enable_in = enable_ff | req_chan.write_data[1:0];
               REG_EN_CLR: enable_in = enable_ff & ~req_chan.write_data[1:0];
               default: ;
            endcase
         end
         default: ;
      endcase

      result.irq = flag_in & ~mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         enable_ff   <= '0;
         div_one_ff  <= '0;
         div_two_ff  <= '0;
         count_ff    <= '0;
         cmpval_ff   <= '0;
         flag_ff     <= 1'b0;
         mask_ff     <= 1'b1;
         free_ff     <= '0;
         latch_ff    <= '0;
      end else if (push) begin
         prescale_ff <= prescale_in;
         enable_ff   <= enable_in;
         div_one_ff  <= div_one_in;
         div_two_ff  <= div_two_in;
         count_ff    <= count_in;
         cmpval_ff   <= cmpval_in;
         flag_ff     <= flag_in;
         mask_ff     <= mask_in;
         free_ff     <= free_in;
         latch_ff    <= latch_in;
      end
   end

   // Two-entry response buffer: the skid entry fills only when the output
   // entry is occupied and not being taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.read_data = out_ff.read_data;
   assign rsp_chan.irq       = out_ff.irq;

endmodule

[hw/rtl/ostc_checker.sv]
// Port-level checker for the system timer, bound to the top level.
// Uses ostc_pkg for command and register codes.
module ostc_checker
   import ostc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input command_type req_command,
   input index_type   req_word_index,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input data_type    rsp_read_data,
   input logic        rsp_irq
);

   logic req_take;
   assign req_take = req_valid && req_ready;

   // Nothing is left in the response buffer after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // An empty buffer always has room for a request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response buffer");

   // A request taken into an empty buffer shows its response in the next cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_take && !rsp_valid) |=> rsp_valid)
      else $error("response did not follow request");

   // A read of the write-only clear register returns zero.
   a_clear_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (req_take && !rsp_valid && req_command == CMD_READ
       && req_word_index == REG_CLEAR) |=> (rsp_read_data == '0))
      else $error("write-only register read nonzero");

   // A stalled response holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_read_data) && $stable(rsp_irq)))
      else $error("stalled response changed");

endmodule

bind os_timer_compare_and_free_counter ostc_checker u_ostc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_command    (req_chan.command),
   .req_word_index (req_chan.word_index),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_read_data  (rsp_chan.read_data),
   .rsp_irq        (rsp_chan.irq)
);

[verif/ostc_response_checker.sv]
// Response checker for the two-channel system timer: tracks the timer state
// from accepted requests and compares every accepted response in order.
// Depends on ostc_pkg and the channel interfaces in ostc_if.sv.
module ostc_response_checker
   import ostc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ostc_req_if        req_chan,
   ostc_rsp_if        rsp_chan,
   output int         mismatch_count,
   output int         responses_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      data_type read_data;
      logic     irq;
   } timer_result_type;

   timer_result_type pending_responses[$];

   // Shadow copy of the timer state.
   logic [3:0]  prescale_codes;
   logic [1:0]  channel_on;
   divider_type div_one;
   divider_type div_two;
   compare_type cmp_count;
   compare_type cmp_value;
   logic        full_flag;
   logic        full_mask;
   free_type    free_count;
   data_type    high_latch;

   // A divider ends its period once its count reaches 4^code - 1.
   function automatic logic period_done(input divider_type cnt, input logic [1:0] code);
      int lim;
      lim = (1 << (2 * code)) - 1;
      return int'(cnt) >= lim;
   endfunction

   task automatic timer_step(input command_type cmd, input index_type idx,
                             input data_type data, output timer_result_type res);
      data_type    rd;
      compare_type next_count;
      rd = '0;
      case (cmd)
         CMD_TICK: begin
            if (channel_on[0]) begin
               if (period_done(div_one, prescale_codes[1:0])) begin
                  div_one    = '0;
                  next_count = cmp_count + 1'b1;
                  if (next_count == cmp_value) begin
                     full_flag = 1'b1;
                     cmp_count = '0;
                  end else begin
                     cmp_count = next_count;
                  end
               end else begin
                  div_one = div_one + 1'b1;
               end
            end
            if (channel_on[1]) begin
               if (period_done(div_two, prescale_codes[3:2])) begin
                  div_two    = '0;
                  free_count = free_count + 1'b1;
               end else begin
                  div_two = div_two + 1'b1;
               end
            end
         end
         CMD_READ: begin
            case (idx)
               REG_PRESCALE: rd = data_type'(prescale_codes);
               REG_FLAG:     rd = data_type'(full_flag);
               REG_MASK:     rd = data_type'(full_mask);
               REG_CMPVAL:   rd = data_type'(cmp_value);
               REG_COUNT:    rd = data_type'(cmp_count);
               REG_FREE_LO: begin
                  high_latch = free_count[FREE_W-1:32];
                  rd         = free_count[31:0];
               end
               REG_FREE_HI:  rd = high_latch;
               default:      rd = '0;
            endcase
         end
         CMD_WRITE: begin
            case (idx)
               REG_PRESCALE: prescale_codes = data[3:0];
               REG_CLEAR: begin
                  if (data[0]) begin
                     cmp_count = '0;
                     div_one   = '0;
                  end
                  if (data[1]) begin
                     free_count = '0;
                     div_two    = '0;
                  end
               end
               REG_FLAG:   if (!data[0]) full_flag = 1'b0;
               REG_MASK:   full_mask = data[0];
               REG_CMPVAL: cmp_value = compare_type'(data);
               REG_COUNT:  cmp_count = compare_type'(data);
               REG_EN_SET: channel_on = channel_on | data[1:0];
               REG_EN_CLR: channel_on = channel_on & ~data[1:0];
               default: ;
            endcase
         end
         default: ;
      endcase
      res.read_data = rd;
      res.irq       = full_flag & ~full_mask;
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("%0t: response mismatch: %s", $realtime, what);
      end
      mismatch_count = mismatch_count + 1;
   endtask

   always @(posedge clock) begin
      timer_result_type exp_res;
      timer_result_type new_res;
      if (reset) begin
         prescale_codes = '0;
         channel_on     = '0;
         div_one        = '0;
         div_two        = '0;
         cmp_count      = '0;
         cmp_value      = '0;
         full_flag      = 1'b0;
         full_mask      = 1'b1;
         free_count     = '0;
         high_latch     = '0;
         pending_responses.delete();
      end else begin
         // Responses go first: a response leaving at this edge always belongs
         // to a request taken at an earlier edge.
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_responses.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction read_data=%h irq=%b",
                                         rsp_chan.read_data, rsp_chan.irq));
            end else begin
               exp_res = pending_responses.pop_front();
               if (rsp_chan.read_data !== exp_res.read_data ||
                   rsp_chan.irq !== exp_res.irq) begin
                  report_mismatch($sformatf(
                     "read_data exp %h got %h, irq exp %b got %b",
                     exp_res.read_data, rsp_chan.read_data, exp_res.irq, rsp_chan.irq));
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            timer_step(req_chan.command, req_chan.word_index, req_chan.write_data, new_res);
            pending_responses.push_back(new_res);
         end
      end
      responses_outstanding = pending_responses.size();
   end

endmodule

[verif/tb_os_timer_compare_and_free_counter.sv]
// Testbench top for the two-channel system timer: drives directed and random
// requests with random idling and a long response hold-off, and gives the
// verdict. Depends on ostc_pkg, ostc_if.sv and ostc_response_checker.
module tb_os_timer_compare_and_free_counter
   import ostc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_GAP      = 20;

   logic clock;
   logic reset;
   logic hold_off;
   logic hold_armed;
   int   send_idle;
   int   recv_idle;
   int   cycle_count = 0;
   int   mismatches;
   int   outstanding;

   ostc_req_if req_chan ();
   ostc_rsp_if rsp_chan ();

   os_timer_compare_and_free_counter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ostc_response_checker resp_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_chan              (req_chan),
      .rsp_chan              (rsp_chan),
      .mismatch_count        (mismatches),
      .responses_outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= !reset && !hold_off && ($urandom_range(99) >= recv_idle);
   end

   // Long receiver stall while the sender keeps offering, so that the
   // response buffer fills and the request side stalls.
   initial begin
      hold_off = 1'b0;
      wait (hold_armed);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Valid stays high from one transaction to the next unless a gap is drawn.
   task automatic send_item(input command_type cmd, input index_type idx,
                            input data_type data);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.word_index <= idx;
      req_chan.write_data <= data;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   initial begin
      index_type   write_targets [8];
      command_type cmd;
      index_type   idx;
      data_type    data;
      int          roll;
      write_targets = '{REG_PRESCALE, REG_CLEAR, REG_FLAG, REG_MASK,
                        REG_CMPVAL, REG_COUNT, REG_EN_SET, REG_EN_CLR};
      hold_armed = 1'b0;
      send_idle  = 18;
      recv_idle  = 85;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.command    <= CMD_TICK;
      req_chan.word_index <= REG_PRESCALE;
      req_chan.write_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset values, write-only and unused indices.
      send_item(CMD_READ, REG_PRESCALE, '0);
      send_item(CMD_READ, REG_FLAG, '0);
      send_item(CMD_READ, REG_MASK, '0);
      send_item(CMD_READ, REG_CMPVAL, '0);
      send_item(CMD_READ, REG_COUNT, '0);
      send_item(CMD_READ, REG_FREE_LO, '0);
      send_item(CMD_READ, REG_FREE_HI, '0);
      send_item(CMD_READ, REG_CLEAR, '1);
      send_item(CMD_READ, REG_EN_SET, '0);
      send_item(CMD_READ, index_type'(15), '0);
      // Unmask, compare at two, enable both channels and reach the compare.
      send_item(CMD_WRITE, REG_MASK, '0);
      send_item(CMD_WRITE, REG_CMPVAL, 32'd2);
      send_item(CMD_WRITE, REG_EN_SET, '1);
      send_item(CMD_TICK, REG_PRESCALE, '0);
      send_item(CMD_TICK, REG_PRESCALE, '1);
      // Writing one to the flag leaves it set, writing zero clears it.
      send_item(CMD_WRITE, REG_FLAG, 32'd1);
      send_item(CMD_WRITE, REG_FLAG, '0);
      // A compare value of zero fires when the count wraps through zero.
      send_item(CMD_WRITE, REG_COUNT, '1);
      send_item(CMD_WRITE, REG_CMPVAL, '0);
      send_item(CMD_TICK, REG_PRESCALE, '0);
      send_item(CMD_WRITE, REG_FREE_LO, '1);
      send_item(CMD_WRITE, REG_PRESCALE, '1);
      send_item(CMD_TICK, REG_PRESCALE, '0);
      send_item(command_type'(3), index_type'(15), '1);
      send_item(CMD_WRITE, REG_CLEAR, '1);
      send_item(CMD_WRITE, REG_EN_CLR, '1);
      send_item(CMD_READ, REG_FREE_LO, '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle = 85;
            recv_idle = 18;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (n == 2 * RANDOM_ITEMS / 3 + 50) hold_armed = 1'b1;
         roll = $urandom_range(99);
         data = $urandom;
         idx  = index_type'($urandom_range(15));
         if (roll < 50) cmd = CMD_TICK;
         else if (roll < 72) cmd = CMD_READ;
         else if (roll < 96) cmd = CMD_WRITE;
         else cmd = command_type'(3);
         if (cmd == CMD_WRITE && $urandom_range(9) < 8) begin
            idx = write_targets[$urandom_range(7)];
         end
         // Small compare values and counts let the compare actually fire.
         if (cmd == CMD_WRITE && idx == REG_CMPVAL && $urandom_range(9) < 7) begin
            data = $urandom_range(40, 1);
         end
         if (cmd == CMD_WRITE && idx == REG_COUNT && $urandom_range(9) < 7) begin
            data = $urandom_range(8);
         end
         send_item(cmd, idx, data);
      end
      req_chan.valid <= 1'b0;

      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/ostc_pkg.sv
hw/rtl/ostc_if.sv
hw/rtl/os_timer_compare_and_free_counter.sv
hw/rtl/ostc_checker.sv
verif/ostc_response_checker.sv
verif/tb_os_timer_compare_and_free_counter.sv
